// ===== rtl/gradient_noise_2d_sampler_macros.svh =====
// Assertion helpers for the noise sampler.
// Both macros sample on clk and are off while arst_n is low.
`ifndef GRADIENT_NOISE_2D_SAMPLER_MACROS_SVH
`define GRADIENT_NOISE_2D_SAMPLER_MACROS_SVH

// Check cons in the same cycle as ante.
`define GN2D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define GN2D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gn2d_pkg.sv =====
package gn2d_pkg;

	// Lattice and fixed-point format
	localparam int CELLS_PER_SIDE = 32;
	localparam int GRAD_FRAC_BITS = 14;
	localparam int POS_FRAC_BITS  = 16;
	localparam int DOT_SCALE_BITS = 16;

	localparam int SIDE  = CELLS_PER_SIDE + 1;
	localparam int DEPTH = SIDE * SIDE;

	// Field widths
	localparam int IDX_W  = 11;
	localparam int GRAD_W = 16;
	localparam int CELL_W = 5;
	localparam int FRAC_W = 16;
	localparam int OUT_W  = 16;

	// Input tdata layout, lowest bit first
	localparam int OFF_IDX = 0;
	localparam int OFF_GX  = OFF_IDX + IDX_W;
	localparam int OFF_GY  = OFF_GX + GRAD_W;
	localparam int OFF_CX  = OFF_GY + GRAD_W;
	localparam int OFF_CY  = OFF_CX + CELL_W;
	localparam int OFF_FX  = OFF_CY + CELL_W;
	localparam int OFF_FY  = OFF_FX + FRAC_W;
	localparam int IN_DATA_W   = OFF_FY + FRAC_W;
	localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Lattice coordinates and parity banks
	localparam int ROW_W      = (SIDE > 2) ? $clog2(SIDE) : 1;
	localparam int CEXT_W     = (CELL_W > ROW_W) ? CELL_W : ROW_W;
	localparam int NBANK      = 4;
	localparam int BANK_COLS  = (SIDE + 1) / 2;
	localparam int BANK_ROWS  = (SIDE + 1) / 2;
	localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
	localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int ENTRY_W    = 2 * GRAD_W;

	// Reciprocal for index / SIDE; estimate is exact or one low
	localparam int DIV_SH  = IDX_W + 1;
	localparam int RECIP   = (1 << DIV_SH) / SIDE;
	localparam int RECIP_W = DIV_SH + 1;
	localparam int QPROD_W = IDX_W + RECIP_W;

	// Position and fade
	localparam int T_W      = POS_FRAC_BITS;
	localparam int POS_ONE  = 1 << POS_FRAC_BITS;
	localparam int POS_HALF = 1 << (POS_FRAC_BITS - 1);
	localparam int FEXT_W   = ((FRAC_W > T_W) ? FRAC_W : T_W) + 1;
	localparam int SQ_W     = 2 * T_W + 1;
	localparam int FS_W     = T_W + 5;
	localparam int F_W      = T_W + 1;
	localparam int FADE_C5  = 6;
	localparam int FADE_C4  = 15;
	localparam int FADE_C3  = 10;

	// Dot products
	localparam int DX_W     = T_W + 1;
	localparam int PROD_W   = GRAD_W + DX_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int DOT_SH   = GRAD_FRAC_BITS + POS_FRAC_BITS - DOT_SCALE_BITS;
	localparam int DOT_RSH  = (DOT_SH > 0) ? DOT_SH : 0;
	localparam int DOT_LSH  = (DOT_SH < 0) ? -DOT_SH : 0;
	localparam int DOT_HALF = (DOT_RSH > 0) ? (1 << (DOT_RSH - 1)) : 0;
	localparam int D_W      = SUM_W - DOT_RSH + DOT_LSH;

	// Interpolation
	localparam int P1_W = F_W + 1 + D_W + 1;
	localparam int L1_W = D_W + 2;
	localparam int P2_W = F_W + 1 + L1_W + 1;
	localparam int L2_W = L1_W + 2;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	// Address of a lattice point inside its parity bank
	function automatic logic [BADDR_W-1:0] bank_addr(input logic [ROW_W-1:0] row,
	                                                 input logic [ROW_W-1:0] col);
		return BADDR_W'(32'(row >> 1) * BANK_COLS + 32'(col >> 1));
	endfunction

endpackage

// ===== rtl/gradient_noise_2d_sampler.sv =====
// 2D gradient noise sampler.
// Input channel s_*: s_tuser is the operation (load a gradient or evaluate a
// point), s_tdata carries the fields listed at the port. A load writes one
// lattice gradient (row-major, row length cells plus one); an evaluate
// returns one noise value in Q1.15 on the output channel m_*. Loads return
// nothing, and out-of-range load indexes are dropped.
// Throughput: one item per cycle while the output is not stalled, loads and
// evaluates mixed freely. The four corner gradients come from four RAM banks
// split by row and column parity, so every evaluate reads each bank once in the same cycle.
// A result passes the pipeline registers (index and range setup, bank
// read, products, fade powers, lerps, output register) before m_tvalid
// shows it. A load writes its bank as it leaves stage 1; any later
// evaluate sees it.
// Reset clears all valid bits. The gradient banks are not cleared: every
// entry must be loaded before an evaluate touches it.
// When m_tready is low the result holds on m_tdata, the pipeline keeps
// accepting items until its bubbles are filled, and then s_tready drops.
`include "gradient_noise_2d_sampler_macros.svh"

module gradient_noise_2d_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata low to high: entry_index, grad_x, grad_y, cell_x, cell_y,
	// frac_x, frac_y, zero fill
	input  logic [gn2d_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tuser: operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: noise_value
	output logic [gn2d_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	// Stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;
	logic en_out;

	assign en_out   = !out_valid_q || m_tready;
	assign en_s10   = !v_s10 || en_out;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = out_valid_q;

	// ---------------- input decode ----------------
	gn2d_pkg::op_t                  op_in;
	logic [gn2d_pkg::IDX_W-1:0]     idx_in;
	logic [gn2d_pkg::CEXT_W-1:0]    cx_ext, cy_ext;
	logic [gn2d_pkg::FEXT_W-1:0]    fx_ext, fy_ext;
	logic [gn2d_pkg::ROW_W-1:0]     cx_in, cy_in;
	logic [gn2d_pkg::T_W-1:0]       t_in, u_in;
	logic [gn2d_pkg::QPROD_W-1:0]   qprod_in;

	assign op_in  = gn2d_pkg::op_t'(s_tuser);
	assign idx_in = s_tdata[gn2d_pkg::OFF_IDX +: gn2d_pkg::IDX_W];
	assign cx_ext = gn2d_pkg::CEXT_W'(s_tdata[gn2d_pkg::OFF_CX +: gn2d_pkg::CELL_W]);
	assign cy_ext = gn2d_pkg::CEXT_W'(s_tdata[gn2d_pkg::OFF_CY +: gn2d_pkg::CELL_W]);
	assign fx_ext = gn2d_pkg::FEXT_W'(s_tdata[gn2d_pkg::OFF_FX +: gn2d_pkg::FRAC_W]);
	assign fy_ext = gn2d_pkg::FEXT_W'(s_tdata[gn2d_pkg::OFF_FY +: gn2d_pkg::FRAC_W]);

	// Clamp cells to the last cell and fractions just below one
	assign cx_in = (cx_ext >= gn2d_pkg::CEXT_W'(gn2d_pkg::CELLS_PER_SIDE)) ?
		gn2d_pkg::ROW_W'(gn2d_pkg::CELLS_PER_SIDE - 1) : cx_ext[gn2d_pkg::ROW_W-1:0];
	assign cy_in = (cy_ext >= gn2d_pkg::CEXT_W'(gn2d_pkg::CELLS_PER_SIDE)) ?
		gn2d_pkg::ROW_W'(gn2d_pkg::CELLS_PER_SIDE - 1) : cy_ext[gn2d_pkg::ROW_W-1:0];
	assign t_in = (fx_ext >= gn2d_pkg::FEXT_W'(gn2d_pkg::POS_ONE)) ?
		gn2d_pkg::T_W'(gn2d_pkg::POS_ONE - 1) : fx_ext[gn2d_pkg::T_W-1:0];
	assign u_in = (fy_ext >= gn2d_pkg::FEXT_W'(gn2d_pkg::POS_ONE)) ?
		gn2d_pkg::T_W'(gn2d_pkg::POS_ONE - 1) : fy_ext[gn2d_pkg::T_W-1:0];

	// Row estimate of a load index by reciprocal multiply
	assign qprod_in = gn2d_pkg::QPROD_W'(idx_in) *
		gn2d_pkg::QPROD_W'(gn2d_pkg::RECIP);

	// ---------------- stage 1 ----------------
	gn2d_pkg::op_t                       op_s1;
	logic [gn2d_pkg::IDX_W-1:0]          idx_s1, qest_s1;
	logic [gn2d_pkg::GRAD_W-1:0]         gx_s1, gy_s1;
	logic [gn2d_pkg::ROW_W-1:0]          cx_s1, cy_s1;
	logic [gn2d_pkg::T_W-1:0]            t_s1, u_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= op_in;
			idx_s1  <= idx_in;
			qest_s1 <= gn2d_pkg::IDX_W'(qprod_in >> gn2d_pkg::DIV_SH);
			gx_s1   <= s_tdata[gn2d_pkg::OFF_GX +: gn2d_pkg::GRAD_W];
			gy_s1   <= s_tdata[gn2d_pkg::OFF_GY +: gn2d_pkg::GRAD_W];
			cx_s1   <= cx_in;
			cy_s1   <= cy_in;
			t_s1    <= t_in;
			u_s1    <= u_in;
		end
	end

	// Finish the division: remainder, one correction step
	logic [gn2d_pkg::IDX_W:0]    q_times_side, rem_l, col_full;
	logic [gn2d_pkg::IDX_W-1:0]  row_full;
	logic                        rem_wrap, load_ok;
	logic [gn2d_pkg::ROW_W-1:0]  row_l, col_l;
	logic [1:0]                  wbank;
	logic [gn2d_pkg::BADDR_W-1:0] waddr;

	assign q_times_side = (gn2d_pkg::IDX_W + 1)'(qest_s1) *
		(gn2d_pkg::IDX_W + 1)'(gn2d_pkg::SIDE);
	assign rem_l    = {1'b0, idx_s1} - q_times_side;
	assign rem_wrap = rem_l >= (gn2d_pkg::IDX_W + 1)'(gn2d_pkg::SIDE);
	assign row_full = rem_wrap ? qest_s1 + gn2d_pkg::IDX_W'(1) : qest_s1;
	assign col_full = rem_wrap ? rem_l - (gn2d_pkg::IDX_W + 1)'(gn2d_pkg::SIDE) : rem_l;
	assign row_l    = row_full[gn2d_pkg::ROW_W-1:0];
	assign col_l    = col_full[gn2d_pkg::ROW_W-1:0];
	assign wbank    = {row_l[0], col_l[0]};
	assign waddr    = gn2d_pkg::bank_addr(row_l, col_l);
	assign load_ok  = v_s1 && (op_s1 == gn2d_pkg::OP_LOAD) &&
		(32'(idx_s1) < 32'(gn2d_pkg::DEPTH));

	// Per-bank write enables and read addresses
	logic [gn2d_pkg::NBANK-1:0]   we;
	logic [gn2d_pkg::BADDR_W-1:0] raddr [gn2d_pkg::NBANK];
	logic [gn2d_pkg::ENTRY_W-1:0] rdata [gn2d_pkg::NBANK];

	always_comb begin
		for (int b = 0; b < gn2d_pkg::NBANK; b++) begin
			logic [gn2d_pkg::ROW_W-1:0] r, c;
			r = cy_s1 + gn2d_pkg::ROW_W'(cy_s1[0] != b[1]);
			c = cx_s1 + gn2d_pkg::ROW_W'(cx_s1[0] != b[0]);
			raddr[b] = gn2d_pkg::bank_addr(r, c);
			we[b]    = en_s2 && load_ok && (wbank == 2'(b));
		end
	end

	// Gradient banks split by row and column parity
	for (genvar gb = 0; gb < gn2d_pkg::NBANK; gb++) begin : g_bank
		gn2d_ram #(
			.WIDTH(gn2d_pkg::ENTRY_W),
			.DEPTH(gn2d_pkg::BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (we[gb]),
			.waddr(waddr),
			.wdata({gy_s1, gx_s1}),
			.re   (en_s2),
			.raddr(raddr[gb]),
			.rdata(rdata[gb])
		);
	end

	// ---------------- stage 2: bank data ----------------
	logic                        cx0_s2, cy0_s2;
	logic [gn2d_pkg::T_W-1:0]    t_s2, u_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cx0_s2 <= cx_s1[0];
			cy0_s2 <= cy_s1[0];
			t_s2   <= t_s1;
			u_s2   <= u_s1;
		end
	end

	// Route banks to corners and form the dot-product terms
	logic signed [gn2d_pkg::PROD_W-1:0] px_c [4];
	logic signed [gn2d_pkg::PROD_W-1:0] py_c [4];
	logic [gn2d_pkg::SQ_W-1:0]          tt_sq, uu_sq;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0]                         bsel;
			logic [gn2d_pkg::ENTRY_W-1:0]       ent;
			logic signed [gn2d_pkg::GRAD_W-1:0] gx, gy;
			logic signed [gn2d_pkg::DX_W-1:0]   dx, dy;
			bsel = {cy0_s2 ^ k[1], cx0_s2 ^ k[0]};
			ent  = rdata[bsel];
			gx   = signed'(ent[gn2d_pkg::GRAD_W-1:0]);
			gy   = signed'(ent[gn2d_pkg::ENTRY_W-1:gn2d_pkg::GRAD_W]);
			// t - one in two's complement is just t with the sign bit set
			dx   = signed'({k[0], t_s2});
			dy   = signed'({k[1], u_s2});
			px_c[k] = gn2d_pkg::PROD_W'(gx) * gn2d_pkg::PROD_W'(dx);
			py_c[k] = gn2d_pkg::PROD_W'(gy) * gn2d_pkg::PROD_W'(dy);
		end
	end

	assign tt_sq = gn2d_pkg::SQ_W'(t_s2) * gn2d_pkg::SQ_W'(t_s2) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);
	assign uu_sq = gn2d_pkg::SQ_W'(u_s2) * gn2d_pkg::SQ_W'(u_s2) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);

	// ---------------- stage 3: products, t^2 ----------------
	logic signed [gn2d_pkg::PROD_W-1:0] px_s3 [4];
	logic signed [gn2d_pkg::PROD_W-1:0] py_s3 [4];
	logic [gn2d_pkg::T_W-1:0]           t_s3, u_s3, t2_s3, u2_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			px_s3 <= px_c;
			py_s3 <= py_c;
			t_s3  <= t_s2;
			u_s3  <= u_s2;
			t2_s3 <= tt_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
			u2_s3 <= uu_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
		end
	end

	// Sum and round each dot product to the 2^16 scale
	logic signed [gn2d_pkg::D_W-1:0] d_c [4];
	logic [gn2d_pkg::SQ_W-1:0]       t3_sq, u3_sq;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [gn2d_pkg::SUM_W-1:0] sum;
			sum = gn2d_pkg::SUM_W'(px_s3[k]) + gn2d_pkg::SUM_W'(py_s3[k]) +
				gn2d_pkg::SUM_W'(gn2d_pkg::DOT_HALF);
			d_c[k] = gn2d_pkg::D_W'(sum >>> gn2d_pkg::DOT_RSH) <<< gn2d_pkg::DOT_LSH;
		end
	end

	assign t3_sq = gn2d_pkg::SQ_W'(t2_s3) * gn2d_pkg::SQ_W'(t_s3) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);
	assign u3_sq = gn2d_pkg::SQ_W'(u2_s3) * gn2d_pkg::SQ_W'(u_s3) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);

	// ---------------- stage 4: dots, t^3 ----------------
	logic signed [gn2d_pkg::D_W-1:0] d_s4 [4];
	logic [gn2d_pkg::T_W-1:0]        t_s4, u_s4, t3_s4, u3_s4;
	logic [gn2d_pkg::SQ_W-1:0]       t4_sq, u4_sq;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d_s4  <= d_c;
			t_s4  <= t_s3;
			u_s4  <= u_s3;
			t3_s4 <= t3_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
			u3_s4 <= u3_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
		end
	end

	assign t4_sq = gn2d_pkg::SQ_W'(t3_s4) * gn2d_pkg::SQ_W'(t_s4) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);
	assign u4_sq = gn2d_pkg::SQ_W'(u3_s4) * gn2d_pkg::SQ_W'(u_s4) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);

	// ---------------- stage 5: t^4 ----------------
	logic signed [gn2d_pkg::D_W-1:0] d_s5 [4];
	logic [gn2d_pkg::T_W-1:0]        t_s5, u_s5, t3_s5, u3_s5, t4_s5, u4_s5;
	logic [gn2d_pkg::SQ_W-1:0]       t5_sq, u5_sq;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			d_s5  <= d_s4;
			t_s5  <= t_s4;
			u_s5  <= u_s4;
			t3_s5 <= t3_s4;
			u3_s5 <= u3_s4;
			t4_s5 <= t4_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
			u4_s5 <= u4_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
		end
	end

	assign t5_sq = gn2d_pkg::SQ_W'(t4_s5) * gn2d_pkg::SQ_W'(t_s5) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);
	assign u5_sq = gn2d_pkg::SQ_W'(u4_s5) * gn2d_pkg::SQ_W'(u_s5) +
		gn2d_pkg::SQ_W'(gn2d_pkg::POS_HALF);

	// ---------------- stage 6: t^5 ----------------
	logic signed [gn2d_pkg::D_W-1:0] d_s6 [4];
	logic [gn2d_pkg::T_W-1:0]        t3_s6, u3_s6, t4_s6, u4_s6, t5_s6, u5_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			d_s6  <= d_s5;
			t3_s6 <= t3_s5;
			u3_s6 <= u3_s5;
			t4_s6 <= t4_s5;
			u4_s6 <= u4_s5;
			t5_s6 <= t5_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
			u5_s6 <= u5_sq[gn2d_pkg::T_W +: gn2d_pkg::T_W];
		end
	end

	// Fade polynomial, clamped to [0, one]
	logic [gn2d_pkg::FS_W-1:0] fxp, fxn, fxd, fyp, fyn, fyd;
	logic [gn2d_pkg::F_W-1:0]  fx_c, fy_c;

	assign fxp = gn2d_pkg::FS_W'(t5_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C5) +
		gn2d_pkg::FS_W'(t3_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C3);
	assign fxn = gn2d_pkg::FS_W'(t4_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C4);
	assign fxd = fxp - fxn;
	assign fyp = gn2d_pkg::FS_W'(u5_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C5) +
		gn2d_pkg::FS_W'(u3_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C3);
	assign fyn = gn2d_pkg::FS_W'(u4_s6) * gn2d_pkg::FS_W'(gn2d_pkg::FADE_C4);
	assign fyd = fyp - fyn;

	assign fx_c = (fxp < fxn) ? '0 :
		(fxd > gn2d_pkg::FS_W'(gn2d_pkg::POS_ONE)) ? gn2d_pkg::F_W'(gn2d_pkg::POS_ONE) :
		fxd[gn2d_pkg::F_W-1:0];
	assign fy_c = (fyp < fyn) ? '0 :
		(fyd > gn2d_pkg::FS_W'(gn2d_pkg::POS_ONE)) ? gn2d_pkg::F_W'(gn2d_pkg::POS_ONE) :
		fyd[gn2d_pkg::F_W-1:0];

	// ---------------- stage 7: fade weights ----------------
	logic signed [gn2d_pkg::D_W-1:0] d_s7 [4];
	logic [gn2d_pkg::F_W-1:0]        fx_s7, fy_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			d_s7  <= d_s6;
			fx_s7 <= fx_c;
			fy_s7 <= fy_c;
		end
	end

	// Scale the x edge differences by fx
	logic signed [gn2d_pkg::D_W:0]    dtop, dbot;
	logic signed [gn2d_pkg::F_W:0]    fxs;
	logic signed [gn2d_pkg::P1_W-1:0] ptop_c, pbot_c;

	assign dtop   = (gn2d_pkg::D_W + 1)'(d_s7[1]) - (gn2d_pkg::D_W + 1)'(d_s7[0]);
	assign dbot   = (gn2d_pkg::D_W + 1)'(d_s7[3]) - (gn2d_pkg::D_W + 1)'(d_s7[2]);
	assign fxs    = signed'({1'b0, fx_s7});
	assign ptop_c = gn2d_pkg::P1_W'(fxs) * gn2d_pkg::P1_W'(dtop);
	assign pbot_c = gn2d_pkg::P1_W'(fxs) * gn2d_pkg::P1_W'(dbot);

	// ---------------- stage 8: x products ----------------
	logic signed [gn2d_pkg::D_W-1:0]  d0_s8, d2_s8;
	logic signed [gn2d_pkg::P1_W-1:0] ptop_s8, pbot_s8;
	logic [gn2d_pkg::F_W-1:0]         fy_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			d0_s8   <= d_s7[0];
			d2_s8   <= d_s7[2];
			ptop_s8 <= ptop_c;
			pbot_s8 <= pbot_c;
			fy_s8   <= fy_s7;
		end
	end

	// Round and add back to get the top and bottom edge values
	logic signed [gn2d_pkg::P1_W-1:0] ptop_r, pbot_r;
	logic signed [gn2d_pkg::L1_W-1:0] top_c, bot_c;

	assign ptop_r = ptop_s8 + gn2d_pkg::P1_W'(gn2d_pkg::POS_HALF);
	assign pbot_r = pbot_s8 + gn2d_pkg::P1_W'(gn2d_pkg::POS_HALF);
	assign top_c  = gn2d_pkg::L1_W'(d0_s8) +
		gn2d_pkg::L1_W'(ptop_r >>> gn2d_pkg::POS_FRAC_BITS);
	assign bot_c  = gn2d_pkg::L1_W'(d2_s8) +
		gn2d_pkg::L1_W'(pbot_r >>> gn2d_pkg::POS_FRAC_BITS);

	// ---------------- stage 9: edge values ----------------
	logic signed [gn2d_pkg::L1_W-1:0] top_s9, bot_s9;
	logic [gn2d_pkg::F_W-1:0]         fy_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			top_s9 <= top_c;
			bot_s9 <= bot_c;
			fy_s9  <= fy_s8;
		end
	end

	// Scale the y difference by fy
	logic signed [gn2d_pkg::L1_W:0]   dy_c;
	logic signed [gn2d_pkg::F_W:0]    fys;
	logic signed [gn2d_pkg::P2_W-1:0] pv_c;

	assign dy_c = (gn2d_pkg::L1_W + 1)'(bot_s9) - (gn2d_pkg::L1_W + 1)'(top_s9);
	assign fys  = signed'({1'b0, fy_s9});
	assign pv_c = gn2d_pkg::P2_W'(fys) * gn2d_pkg::P2_W'(dy_c);

	// ---------------- stage 10: y product ----------------
	logic signed [gn2d_pkg::L1_W-1:0] top_s10;
	logic signed [gn2d_pkg::P2_W-1:0] pv_s10;

	always_ff @(posedge clk) begin
		if (en_s10) begin
			top_s10 <= top_s9;
			pv_s10  <= pv_c;
		end
	end

	// Final lerp, halve to Q1.15 and saturate
	logic signed [gn2d_pkg::P2_W-1:0]   pv_r;
	logic signed [gn2d_pkg::L2_W-1:0]   lerp_c, half_c;
	logic [gn2d_pkg::L2_W-gn2d_pkg::OUT_W:0] hi_bits;
	logic                               ovf;
	logic [gn2d_pkg::OUT_W-1:0]         noise_c, noise_q;

	assign pv_r    = pv_s10 + gn2d_pkg::P2_W'(gn2d_pkg::POS_HALF);
	assign lerp_c  = gn2d_pkg::L2_W'(top_s10) +
		gn2d_pkg::L2_W'(pv_r >>> gn2d_pkg::POS_FRAC_BITS);
	assign half_c  = (lerp_c + gn2d_pkg::L2_W'(1)) >>> 1;
	assign hi_bits = half_c[gn2d_pkg::L2_W-1:gn2d_pkg::OUT_W-1];
	assign ovf     = !((&hi_bits) || !(|hi_bits));
	assign noise_c = ovf ? (half_c[gn2d_pkg::L2_W-1] ? gn2d_pkg::OUT_MIN : gn2d_pkg::OUT_MAX) :
		half_c[gn2d_pkg::OUT_W-1:0];

	// Output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			noise_q <= noise_c;
		end
	end

	assign m_tdata = gn2d_pkg::OUT_TDATA_W'(noise_q);

	// ---------------- valid bits ----------------
	// Advance each valid with its stage; loads leave after the bank write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= s_tvalid;
			if (en_s2)  v_s2  <= v_s1 && (op_s1 == gn2d_pkg::OP_EVAL);
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_out) out_valid_q <= v_s10;
		end
	end

	// ---------------- assertions ----------------
	`GN2D_ASSERT_NOW(a_one_bank_write, 1'b1, $onehot0(we), "load wrote more than one bank")
	`GN2D_ASSERT_NOW(a_fade_range, v_s7, (fx_s7 <= gn2d_pkg::F_W'(gn2d_pkg::POS_ONE)) && (fy_s7 <= gn2d_pkg::F_W'(gn2d_pkg::POS_ONE)), "fade weight above one")
	`GN2D_ASSERT_NXT(a_s10_hold, v_s10 && !en_s10, v_s10 && $stable(top_s10) && $stable(pv_s10), "stalled stage lost its item")
	`GN2D_ASSERT_NXT(a_result_out, v_s10 && en_out, out_valid_q, "finished item not presented")

endmodule

// ===== rtl/gn2d_ram.sv =====
module gn2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
